@@ rtl/assert_macros.svh @@
// Assertion helpers included by the dispatcher RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle
`define ERBD_ASSERT_IMP(lbl, clk, rst, cond, expct) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expct)) \
    else $error("same-cycle check failed");

// Check that a condition implies another in the next cycle
`define ERBD_ASSERT_NXT(lbl, clk, rst, cond, expct) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expct)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/erbd_pkg.sv @@
package erbd_pkg;

  // Operation codes of an input transaction
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_POLL    = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  localparam logic [15:0] EPOCH_TOTAL_RESET = 16'd4;

  typedef struct packed {
    logic        operation;
    logic [2:0]  agent_id;
    logic [31:0] request_epoch;
    logic [31:0] start_value;
    logic [31:0] count_value;
    logic        workers_idle;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        accepted;
    logic [2:0]  out_agent;
    logic [31:0] out_epoch;
    logic [31:0] out_start;
    logic [31:0] out_count;
    logic        finished;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] start_value;
    logic [31:0] count_value;
  } slot_data_t;

  // Write strobes toward the slot memories
  typedef struct packed {
    logic filled_we;
    logic filled_wval;
    logic data_we;
  } slot_cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REQ_CHECK,
    ST_REQ_READ,
    ST_REQ_DONE,
    ST_SCAN_READ,
    ST_SCAN_CHECK,
    ST_REL_READ,
    ST_REL_OUT,
    ST_STATUS
  } state_t;

endpackage

@@ rtl/epoch_reorder_barrier_dispatch.sv @@
// Reorder barrier dispatcher: each agent's requests sit in a reorder queue in
// slot memory, indexed by epoch minus the current round, and a poll releases
// all agents' head entries together once every head is filled and no earlier
// release still waits for idle workers. After reset the block clears every
// occupancy slot and takes no input transaction meanwhile (configuration
// writes are always taken). A request then checks its range, reads its slot
// and answers; a poll answers with status directly or after checking heads
// in turn, and a releasing poll checks every head, then reads and releases
// each one in turn. These steps come from the single-port slot memory with
// its registered read: each head is read once to check it and once more to
// fetch its payload. Output back-pressure adds its own stall cycles.
module epoch_reorder_barrier_dispatch
  import erbd_pkg::*;
#(
  parameter int NUM_AGENTS  = 2,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  `include "assert_macros.svh"

  localparam int MEM_DEPTH = NUM_AGENTS * QUEUE_DEPTH;
  localparam int MW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int IW        = $clog2(QUEUE_DEPTH);
  localparam int AW        = (NUM_AGENTS > 1) ? $clog2(NUM_AGENTS) : 1;

  state_t            state, state_next;
  in_t               item, item_next;
  logic [AW-1:0]     agent, agent_next;
  logic              pre_ok, pre_ok_next;
  logic [IW-1:0]     idx, idx_next;
  logic [IW-1:0]     head [NUM_AGENTS];
  logic [IW-1:0]     head_next [NUM_AGENTS];
  logic [IW:0]       len [NUM_AGENTS];
  logic [IW:0]       len_next [NUM_AGENTS];
  logic [31:0]       round, round_next;
  logic [31:0]       pending, pending_next;
  logic              waiting, waiting_next;
  logic [15:0]       epoch_total;
  logic [MW-1:0]     clr_addr, clr_addr_next;

  logic [MW-1:0]     mem_addr;
  slot_cmd_t         cmd;
  logic              rd_filled;
  slot_data_t        rd_data;
  logic              push;
  out_t              push_data;
  logic              space;
  logic [31:0]       diff;
  logic              agent_last;
  logic              rel_push;

  // Add an offset to a head pointer, wrapping at the queue depth
  function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] base, logic [IW-1:0] off);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IW+1)'(QUEUE_DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  // Flat slot address of one agent's queue position
  function automatic logic [MW-1:0] slot_addr(logic [AW-1:0] ag, logic [IW-1:0] pos);
    logic [MW:0] full;
    full = (MW+1)'(ag) * (MW+1)'(QUEUE_DEPTH) + (MW+1)'(pos);
    return full[MW-1:0];
  endfunction

  assign in_ready   = (state == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign diff       = item.request_epoch - round;
  assign agent_last = (agent == AW'(NUM_AGENTS - 1));
  assign rel_push   = push && (push_data.kind == KIND_RELEASE);

  // Select the memory address for the current step
  always_comb begin
    case (state)
      ST_CLEAR: mem_addr = clr_addr;
      ST_REQ_READ, ST_REQ_DONE: mem_addr = slot_addr(agent, wrap_add(head[agent], idx));
      default: mem_addr = slot_addr(agent, head[agent]);
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch_total <= EPOCH_TOTAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      epoch_total <= cfg_data;
    end
  end

  // State and queue registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      round    <= '0;
      pending  <= '0;
      waiting  <= 1'b0;
      agent    <= '0;
      for (int i = 0; i < NUM_AGENTS; i++) begin
        head[i] <= '0;
        len[i]  <= '0;
      end
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      round    <= round_next;
      pending  <= pending_next;
      waiting  <= waiting_next;
      agent    <= agent_next;
      for (int i = 0; i < NUM_AGENTS; i++) begin
        head[i] <= head_next[i];
        len[i]  <= len_next[i];
      end
    end
  end

  // Item and check registers carry payload only
  always_ff @(posedge clk) begin
    item   <= item_next;
    pre_ok <= pre_ok_next;
    idx    <= idx_next;
  end

  // Sequencer: next state, memory strobes and results
  always_comb begin
    state_next    = state;
    item_next     = item;
    agent_next    = agent;
    pre_ok_next   = pre_ok;
    idx_next      = idx;
    round_next    = round;
    pending_next  = pending;
    waiting_next  = waiting;
    clr_addr_next = clr_addr;
    for (int i = 0; i < NUM_AGENTS; i++) begin
      head_next[i] = head[i];
      len_next[i]  = len[i];
    end
    cmd       = '0;
    push      = 1'b0;
    push_data = '0;

    case (state)
      ST_CLEAR: begin
        cmd.filled_we   = 1'b1;
        cmd.filled_wval = 1'b0;
        clr_addr_next   = clr_addr + MW'(1);
        if (clr_addr == MW'(MEM_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          item_next  = in_data;
          agent_next = '0;
          if (in_data.operation == OP_REQUEST) begin
            state_next = ST_REQ_CHECK;
          end else if (pending >= 32'(NUM_AGENTS) && !waiting) begin
            state_next = ST_SCAN_READ;
          end else begin
            state_next = ST_STATUS;
          end
        end
      end

      // Range checks on agent and epoch
      ST_REQ_CHECK: begin
        pre_ok_next = ({1'b0, item.agent_id} < 4'(NUM_AGENTS))
                      && (item.request_epoch < {16'b0, epoch_total})
                      && (item.request_epoch >= round)
                      && (diff < 32'(QUEUE_DEPTH));
        idx_next    = diff[IW-1:0];
        if ({1'b0, item.agent_id} < 4'(NUM_AGENTS)) begin
          agent_next = item.agent_id[AW-1:0];
        end
        state_next  = ST_REQ_READ;
      end

      ST_REQ_READ: begin
        state_next = ST_REQ_DONE;
      end

      // Store the request if it passed the checks and its slot is empty, then answer
      ST_REQ_DONE: begin
        if (space) begin
          push               = 1'b1;
          push_data.kind     = KIND_REQUEST;
          push_data.accepted = pre_ok && !rd_filled;
          push_data.last     = 1'b1;
          if (pre_ok && !rd_filled) begin
            cmd.filled_we   = 1'b1;
            cmd.filled_wval = 1'b1;
            cmd.data_we     = 1'b1;
            pending_next    = pending + 32'd1;
            if ({1'b0, idx} >= len[agent]) begin
              len_next[agent] = {1'b0, idx} + (IW+1)'(1);
            end
          end
          state_next = ST_IDLE;
        end
      end

      ST_SCAN_READ: begin
        state_next = ST_SCAN_CHECK;
      end

      // Check one head; move on or give up
      ST_SCAN_CHECK: begin
        if (!rd_filled) begin
          state_next = ST_STATUS;
        end else if (agent_last) begin
          agent_next = '0;
          state_next = ST_REL_READ;
        end else begin
          agent_next = agent + AW'(1);
          state_next = ST_SCAN_READ;
        end
      end

      ST_REL_READ: begin
        state_next = ST_REL_OUT;
      end

      // Release one head, drop its slot and advance the queue
      ST_REL_OUT: begin
        if (space) begin
          push                = 1'b1;
          push_data.kind      = KIND_RELEASE;
          push_data.out_agent = 3'(agent);
          push_data.out_epoch = round;
          push_data.out_start = rd_data.start_value;
          push_data.out_count = rd_data.count_value;
          push_data.last      = agent_last;
          cmd.filled_we       = 1'b1;
          cmd.filled_wval     = 1'b0;
          head_next[agent]    = wrap_add(head[agent], IW'(1));
          len_next[agent]     = len[agent] - (IW+1)'(1);
          if (agent_last) begin
            waiting_next = 1'b1;
            round_next   = round + 32'd1;
            pending_next = pending - 32'(NUM_AGENTS);
            state_next   = ST_IDLE;
          end else begin
            agent_next = agent + AW'(1);
            state_next = ST_REL_READ;
          end
        end
      end

      // Report status; idle workers clear the wait
      ST_STATUS: begin
        if (space) begin
          push               = 1'b1;
          push_data.kind     = KIND_STATUS;
          push_data.finished = item.workers_idle && (round >= {16'b0, epoch_total});
          push_data.last     = 1'b1;
          if (item.workers_idle) begin
            waiting_next = 1'b0;
          end
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  erbd_slot_mem #(
    .MEM_DEPTH (MEM_DEPTH),
    .ADDR_W    (MW)
  ) u_slot_mem (
    .clk       (clk),
    .addr      (mem_addr),
    .cmd       (cmd),
    .wr_data   ({item.start_value, item.count_value}),
    .rd_filled (rd_filled),
    .rd_data   (rd_data)
  );

  erbd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `ERBD_ASSERT_NXT(a_accept_blocks, clk, rst, in_valid && in_ready, !in_ready)
  `ERBD_ASSERT_IMP(a_push_has_room, clk, rst, push, !out_valid || out_ready)
  `ERBD_ASSERT_IMP(a_release_not_waiting, clk, rst, rel_push, !waiting)
  `ERBD_ASSERT_NXT(a_release_sets_wait, clk, rst, rel_push && push_data.last, waiting)

endmodule

@@ rtl/erbd_slot_mem.sv @@
module erbd_slot_mem
  import erbd_pkg::*;
#(
  parameter int MEM_DEPTH = 16,
  parameter int ADDR_W    = 4
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] addr,
  input  slot_cmd_t         cmd,
  input  slot_data_t        wr_data,
  output logic              rd_filled,
  output slot_data_t        rd_data
);

  logic       filled_mem [MEM_DEPTH];
  slot_data_t data_mem   [MEM_DEPTH];

  // Occupancy memory: cleared by the sweep after reset
  always_ff @(posedge clk) begin
    if (cmd.filled_we) begin
      filled_mem[addr] <= cmd.filled_wval;
    end
    rd_filled <= filled_mem[addr];
  end

  // Payload memory: written only when a request is stored
  always_ff @(posedge clk) begin
    if (cmd.data_we) begin
      data_mem[addr] <= wr_data;
    end
    rd_data <= data_mem[addr];
  end

endmodule

@@ rtl/erbd_out_reg.sv @@
module erbd_out_reg
  import erbd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  out_t push_data,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  assign space = !out_valid || out_ready;

  // Hold one result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data <= push_data;
    end
  end

endmodule
